// ===== rtl/core/nn_weight_update_engine_assert.svh =====
// Assertion macros shared by the weight update engine modules.
`ifndef NN_WEIGHT_UPDATE_ENGINE_ASSERT_SVH
`define NN_WEIGHT_UPDATE_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

`define NWU_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("nwu: same-cycle check failed");

`define NWU_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("nwu: next-cycle check failed");

`else

`define NWU_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)

`define NWU_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

// ===== rtl/core/nwu_pkg.sv =====
// Types, constants and helpers of the weight update engine.
package nwu_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int SCALE_W     = 35;
  localparam int SCALE_SPLIT = 18;
  localparam int DIV_STEPS   = SCALE_W;
  localparam int CNT_W       = 6;
  localparam int PIPE_DEPTH  = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int WIDE_W      = 60;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(10 * (1 << FRAC_BITS));
  localparam logic [30:0] LEARN_RESET = 31'(1 << FRAC_BITS);
  localparam logic [15:0] MOM_RESET   = 16'd32768;
  localparam logic [15:0] BATCH_RESET = 16'd1;

  localparam logic [22:0] GAIN_STEP  = 23'(((5 << FRAC_BITS) + 50) / 100);
  localparam logic [15:0] GAIN_DECAY = 16'(((95 << FRAC_BITS) + 50) / 100);
  localparam logic [22:0] GAIN_MIN   = 23'(((1 << FRAC_BITS) + 50) / 100);
  localparam logic [22:0] GAIN_MAX   = 23'(100 << FRAC_BITS);

  localparam logic signed [WIDE_W-1:0] VAL_MAX =
    (WIDE_W'(1) <<< (VALUE_WIDTH - 1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] VAL_MIN = -VAL_MAX - WIDE_W'(1);

  localparam logic [CFG_IDX_W-1:0] REG_RULE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEARN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH = 3'd3;

  typedef enum logic [1:0] {
    RULE_NONE  = 2'd0,
    RULE_FIXED = 2'd1,
    RULE_MOM   = 2'd2,
    RULE_ADAPT = 2'd3
  } rule_t;

  typedef struct packed {
    logic signed [31:0] weight_in;
    logic signed [31:0] grad_sum;
    logic signed [31:0] velocity_in;
    logic [22:0]        gain_in;
    logic signed [31:0] prev_grad;
  } nwu_in_t;

  typedef struct packed {
    logic signed [31:0] weight_out;
    logic signed [31:0] velocity_out;
    logic [22:0]        gain_out;
    logic signed [31:0] prev_grad_out;
    logic               saturated;
  } nwu_out_t;

  typedef struct packed {
    rule_t              rule;
    logic [15:0]        mom_factor;
    logic [SCALE_W-1:0] scale;
    logic               dividing;
  } nwu_cfg_t;

  // sign-extend a 32-bit value to the wide working width
  function automatic logic [WIDE_W-1:0] sx32(input logic [31:0] x);
    return {{(WIDE_W - 32){x[31]}}, x};
  endfunction

  // clip to the signed value range; top bit of the result is the clip flag
  function automatic logic [VALUE_WIDTH:0] sat_val(input logic [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] s;
    s = $signed(v);
    if (s > VAL_MAX) begin
      return {1'b1, VAL_MAX[VALUE_WIDTH-1:0]};
    end else if (s < VAL_MIN) begin
      return {1'b1, VAL_MIN[VALUE_WIDTH-1:0]};
    end
    return {1'b0, v[VALUE_WIDTH-1:0]};
  endfunction

endpackage

// ===== rtl/core/nwu_cfg.sv =====
// Configuration registers and the bit-serial divider that forms the step scale.
module nwu_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nwu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output nwu_pkg::nwu_cfg_t             cfg_st
);
  import nwu_pkg::*;

  `include "nn_weight_update_engine_assert.svh"

  rule_t              rule_r, rule_nxt;
  logic [30:0]        lr_r, lr_nxt;
  logic [15:0]        mf_r, mf_nxt;
  logic [15:0]        bc_r, bc_nxt;
  logic [SCALE_W-1:0] scale_r, scale_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SCALE_W-1:0] quo_r, quo_nxt;
  logic [15:0]        rem_r, rem_nxt;

  logic        wr;
  logic        load;
  logic        dividing;
  logic [16:0] shifted;
  logic [16:0] divisor;
  logic        ge;

  assign dividing  = (cnt_r != '0);
  assign cfg_ready = !dividing;
  assign wr        = cfg_valid && cfg_ready;

  // a zero batch count divides by one
  assign divisor = (bc_r == '0) ? 17'd1 : {1'b0, bc_r};
  assign shifted = {rem_r, quo_r[SCALE_W-1]};
  assign ge      = (shifted >= divisor);

  always_comb begin
    rule_nxt  = rule_r;
    lr_nxt    = lr_r;
    mf_nxt    = mf_r;
    bc_nxt    = bc_r;
    scale_nxt = scale_r;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    load      = 1'b0;
    if (wr) begin
      case (cfg_index)
        REG_RULE: begin
          rule_nxt = rule_t'(cfg_data[1:0]);
        end
        REG_LEARN: begin
          lr_nxt = cfg_data[30:0];
          load   = 1'b1;
        end
        REG_MOM: begin
          mf_nxt = cfg_data[15:0];
        end
        REG_BATCH: begin
          bc_nxt = cfg_data[15:0];
          load   = 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (load) begin
      // dividend is ten times the learning rate
      quo_nxt = ({4'b0, lr_nxt} << 3) + ({4'b0, lr_nxt} << 1);
      rem_nxt = '0;
      cnt_nxt = CNT_W'(DIV_STEPS);
    end else if (dividing) begin
      rem_nxt = ge ? 16'(shifted - divisor) : shifted[15:0];
      quo_nxt = {quo_r[SCALE_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        scale_nxt = {quo_r[SCALE_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r  <= RULE_NONE;
      lr_r    <= LEARN_RESET;
      mf_r    <= MOM_RESET;
      bc_r    <= BATCH_RESET;
      scale_r <= SCALE_RESET;
      cnt_r   <= '0;
    end else begin
      rule_r  <= rule_nxt;
      lr_r    <= lr_nxt;
      mf_r    <= mf_nxt;
      bc_r    <= bc_nxt;
      scale_r <= scale_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign cfg_st = '{rule: rule_r, mom_factor: mf_r, scale: scale_r, dividing: dividing};

  `NWU_ASSERT_NXT(a_div_starts, clk, rst_n,
    wr && (cfg_index == REG_LEARN || cfg_index == REG_BATCH), dividing)
  `NWU_ASSERT_NXT(a_div_ends, clk, rst_n, cnt_r == CNT_W'(1), !dividing)
  `NWU_ASSERT_NXT(a_scale_holds, clk, rst_n, !dividing && !wr, $stable(scale_r))

endmodule

// ===== rtl/core/nwu_pipe.sv =====
// Seven-stage update datapath: products split into partial products, then summed and clipped.
module nwu_pipe (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  nwu_pkg::nwu_in_t  in_data,
  input  nwu_pkg::nwu_cfg_t cfg_st,
  output logic              out_valid,
  output nwu_pkg::nwu_out_t out_data
);
  import nwu_pkg::*;

  `include "nn_weight_update_engine_assert.svh"

  // per-item results carried down the pipe next to the input word
  typedef struct packed {
    logic        gneg;
    logic [31:0] gmag;
    logic [22:0] gain;
    logic [31:0] vel;
    logic [31:0] wfix;
    logic        ffix;
    logic [31:0] wmom;
    logic        fmom;
  } side_t;

  logic [PIPE_DEPTH-1:0] vld_r;
  nwu_in_t               item_r [0:PIPE_DEPTH-2];
  side_t                 side_r [0:PIPE_DEPTH-2];
  side_t                 side0_nxt, side1_nxt, side2_nxt, side3_nxt, side4_nxt, side5_nxt;

  // stage A
  logic [31:0] g_u, pg_u, v_u, vmag;
  logic        same_nxt;
  logic        same_r, vneg_r;
  logic [47:0] mom_prod_r, mom_prod_nxt;
  logic [38:0] dec_prod_r, dec_prod_nxt;
  logic [23:0] inc_r, inc_nxt;
  logic [48:0] sch_r, sch_nxt;
  logic [49:0] scl_r, scl_nxt;
  // stage B
  logic [23:0] gsel;
  logic [66:0] sgm_sum;
  logic [50:0] sgm_r, sgm_nxt;
  logic [32:0] mom_mag, mom_r, mom_nxt;
  // stage C
  logic [WIDE_W-1:0] sgm_w, sgm_s, vraw, wraw;
  logic [32:0]       vsat, wsat;
  logic [39:0]       sgh_r, sgh_nxt;
  logic [40:0]       sgl_r, sgl_nxt;
  // stage D
  logic [57:0]       sg_sum;
  logic [41:0]       sg_r, sg_nxt;
  logic [32:0]       msat;
  // stage E
  logic [52:0]       pah_r, pah_nxt, pal_r, pal_nxt;
  // stage F
  logic [73:0]       pa_sum;
  logic [57:0]       pa_r, pa_nxt;
  // stage G
  logic [WIDE_W-1:0] pa_w, pa_s;
  logic [32:0]       asat;
  nwu_out_t          out_r, out_nxt;

  always_comb begin
    g_u      = in_data.grad_sum;
    pg_u     = in_data.prev_grad;
    v_u      = in_data.velocity_in;
    vmag     = v_u[31] ? (~v_u + 32'd1) : v_u;
    same_nxt = (!g_u[31] && g_u != '0 && !pg_u[31] && pg_u != '0) || (g_u[31] && pg_u[31]);
    side0_nxt      = '0;
    side0_nxt.gneg = g_u[31];
    side0_nxt.gmag = g_u[31] ? (~g_u + 32'd1) : g_u;
    mom_prod_nxt = {32'b0, cfg_st.mom_factor} * {16'b0, vmag};
    dec_prod_nxt = {16'b0, in_data.gain_in} * {23'b0, GAIN_DECAY};
    inc_nxt      = {1'b0, in_data.gain_in} + {1'b0, GAIN_STEP};
    sch_nxt      = {32'b0, cfg_st.scale[SCALE_W-1:SCALE_SPLIT]} * {17'b0, side0_nxt.gmag};
    scl_nxt      = {32'b0, cfg_st.scale[SCALE_SPLIT-1:0]} * {18'b0, side0_nxt.gmag};
  end

  // stage B: new gain, scale*grad, momentum*velocity
  always_comb begin
    side1_nxt = side_r[0];
    gsel = same_r ? inc_r : {1'b0, dec_prod_r[38:FRAC_BITS]};
    if (gsel > {1'b0, GAIN_MAX}) begin
      side1_nxt.gain = GAIN_MAX;
    end else if (gsel < {1'b0, GAIN_MIN}) begin
      side1_nxt.gain = GAIN_MIN;
    end else begin
      side1_nxt.gain = gsel[22:0];
    end
    sgm_sum = {sch_r, 18'b0} + {17'b0, scl_r};
    sgm_nxt = sgm_sum[66:FRAC_BITS];
    mom_mag = {1'b0, mom_prod_r[47:16]};
    mom_nxt = vneg_r ? (~mom_mag + 33'd1) : mom_mag;
  end

  // stage C: velocity and fixed-rate weight, scale*gain partials
  always_comb begin
    side2_nxt = side_r[1];
    sgm_w = {9'b0, sgm_r};
    sgm_s = side_r[1].gneg ? (~sgm_w + WIDE_W'(1)) : sgm_w;
    vraw  = {{(WIDE_W - 33){mom_r[32]}}, mom_r} - sgm_s;
    wraw  = sx32(item_r[1].weight_in) - sgm_s;
    vsat  = sat_val(vraw);
    wsat  = sat_val(wraw);
    side2_nxt.vel  = vsat[31:0];
    side2_nxt.fmom = vsat[32];
    side2_nxt.wfix = wsat[31:0];
    side2_nxt.ffix = wsat[32];
    sgh_nxt = {23'b0, cfg_st.scale[SCALE_W-1:SCALE_SPLIT]} * {17'b0, side_r[1].gain};
    sgl_nxt = {23'b0, cfg_st.scale[SCALE_SPLIT-1:0]} * {18'b0, side_r[1].gain};
  end

  // stage D: momentum weight, sum scale*gain
  always_comb begin
    side3_nxt = side_r[2];
    msat = sat_val(sx32(item_r[2].weight_in) + sx32(side_r[2].vel));
    side3_nxt.wmom = msat[31:0];
    side3_nxt.fmom = side_r[2].fmom | msat[32];
    sg_sum = {sgh_r, 18'b0} + {17'b0, sgl_r};
    sg_nxt = sg_sum[57:FRAC_BITS];
  end

  // stage E: split the adaptive step product
  always_comb begin
    side4_nxt = side_r[3];
    pah_nxt = {32'b0, sg_r[41:21]} * {21'b0, side_r[3].gmag};
    pal_nxt = {32'b0, sg_r[20:0]} * {21'b0, side_r[3].gmag};
  end

  // stage F: sum the partials
  always_comb begin
    side5_nxt = side_r[4];
    pa_sum = {pah_r, 21'b0} + {21'b0, pal_r};
    pa_nxt = pa_sum[73:FRAC_BITS];
  end

  // stage G: adaptive weight and rule select
  always_comb begin
    pa_w = {2'b0, pa_r};
    pa_s = side_r[5].gneg ? (~pa_w + WIDE_W'(1)) : pa_w;
    asat = sat_val(sx32(item_r[5].weight_in) - pa_s);
    out_nxt.weight_out    = item_r[5].weight_in;
    out_nxt.velocity_out  = item_r[5].velocity_in;
    out_nxt.gain_out      = item_r[5].gain_in;
    out_nxt.prev_grad_out = item_r[5].prev_grad;
    out_nxt.saturated     = 1'b0;
    case (cfg_st.rule)
      RULE_NONE: begin
      end
      RULE_FIXED: begin
        out_nxt.weight_out = side_r[5].wfix;
        out_nxt.saturated  = side_r[5].ffix;
      end
      RULE_MOM: begin
        out_nxt.weight_out   = side_r[5].wmom;
        out_nxt.velocity_out = side_r[5].vel;
        out_nxt.saturated    = side_r[5].fmom;
      end
      RULE_ADAPT: begin
        out_nxt.weight_out    = asat[31:0];
        out_nxt.gain_out      = side_r[5].gain;
        out_nxt.prev_grad_out = item_r[5].grad_sum;
        out_nxt.saturated     = asat[32];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    item_r[0] <= in_data;
    for (int k = 1; k < PIPE_DEPTH - 1; k++) begin
      item_r[k] <= item_r[k-1];
    end
    side_r[0]  <= side0_nxt;
    side_r[1]  <= side1_nxt;
    side_r[2]  <= side2_nxt;
    side_r[3]  <= side3_nxt;
    side_r[4]  <= side4_nxt;
    side_r[5]  <= side5_nxt;
    same_r     <= same_nxt;
    vneg_r     <= v_u[31];
    mom_prod_r <= mom_prod_nxt;
    dec_prod_r <= dec_prod_nxt;
    inc_r      <= inc_nxt;
    sch_r      <= sch_nxt;
    scl_r      <= scl_nxt;
    sgm_r      <= sgm_nxt;
    mom_r      <= mom_nxt;
    sgh_r      <= sgh_nxt;
    sgl_r      <= sgl_nxt;
    sg_r       <= sg_nxt;
    pah_r      <= pah_nxt;
    pal_r      <= pal_nxt;
    pa_r       <= pa_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = vld_r[PIPE_DEPTH-1];
  assign out_data  = out_r;

  `NWU_ASSERT_IMP(a_out_follows_in, clk, rst_n, out_valid, $past(in_valid, PIPE_DEPTH))
  `NWU_ASSERT_IMP(a_gain_clamped, clk, rst_n,
    out_valid && cfg_st.rule == RULE_ADAPT,
    out_data.gain_out >= GAIN_MIN && out_data.gain_out <= GAIN_MAX)
  `NWU_ASSERT_IMP(a_none_no_clip, clk, rst_n,
    out_valid && cfg_st.rule == RULE_NONE, !out_data.saturated)

endmodule

// ===== rtl/core/nn_weight_update_engine.sv =====
// Top level of the per-weight update engine.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------------
//  input   | start, busy, in_data                    | word taken when start & !busy
//  result  | out_valid, out_data                     | one-cycle strobe, no back-pressure
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | write when cfg_valid & cfg_ready
//
// One word enters per cycle while busy is low; its result passes the registered stages
// A to G in order and leaves with its out_valid strobe.
// A write to learn_rate or batch_count reruns the scale divider, one quotient bit
// per cycle until the new scale is formed, with busy and !cfg_ready held throughout.
// busy is also high in any cycle in which cfg_valid is high.
// After reset the scale is already 10.0 and no item is in flight.
// The result side has no stall; the pipe advances every cycle.
module nn_weight_update_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  nwu_pkg::nwu_in_t              in_data,
  output logic                          out_valid,
  output nwu_pkg::nwu_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nwu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import nwu_pkg::*;

  nwu_cfg_t cfg_st;
  logic     accept;

  // hold off words while the scale is recomputed or a register is written
  assign busy   = cfg_st.dividing | cfg_valid;
  assign accept = start & ~busy;

  nwu_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_st    (cfg_st)
  );

  nwu_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_data   (in_data),
    .cfg_st    (cfg_st),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the per-weight update engine.
module testbench;
  import nwu_pkg::*;

  localparam int MOM_SHIFT = 16;
  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  nwu_in_t              in_data;
  logic                 out_valid;
  nwu_out_t             out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  // register copies as the engine should hold them
  rule_t       cur_rule  = RULE_NONE;
  logic [30:0] cur_learn = LEARN_RESET;
  logic [15:0] cur_mom   = MOM_RESET;
  logic [15:0] cur_batch = BATCH_RESET;

  nwu_out_t pending_updates[$];
  int       fail_count = 0;
  int       n_checked  = 0;
  int       n_settings = 0;
  bit       steady_flow = 1'b0;

  nn_weight_update_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // (a * b) >> sh with the magnitude truncated toward zero
  function automatic longint scaled_product(input logic [63:0] a, input longint b,
                                            input int sh);
    logic [127:0] p;
    logic [63:0]  mag;
    logic [63:0]  q;
    mag = (b < 0) ? 64'(-b) : 64'(b);
    p = {64'd0, a} * {64'd0, mag};
    q = 64'(p >> sh);
    return (b < 0) ? -longint'(q) : longint'(q);
  endfunction

  // top bit flags a clip
  function automatic logic [32:0] clip32(input longint v);
    if (v > WORD_MAX) return {1'b1, 32'h7FFF_FFFF};
    if (v < WORD_MIN) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  function automatic nwu_out_t predict_update(input nwu_in_t rec);
    longint      w, g, v, pg;
    logic [63:0] gain, scale, div, sg;
    logic [32:0] c;
    logic        clipped;
    nwu_out_t    r;
    w = longint'($signed(rec.weight_in));
    g = longint'($signed(rec.grad_sum));
    v = longint'($signed(rec.velocity_in));
    pg = longint'($signed(rec.prev_grad));
    gain = 64'(rec.gain_in);
    clipped = 1'b0;
    div = (cur_batch == 16'd0) ? 64'd1 : 64'(cur_batch);
    scale = (64'd10 * 64'(cur_learn)) / div;
    case (cur_rule)
      RULE_FIXED: begin
        c = clip32(w - scaled_product(scale, g, FRAC_BITS));
        w = longint'($signed(c[31:0]));
        clipped = c[32];
      end
      RULE_MOM: begin
        c = clip32(scaled_product(64'(cur_mom), v, MOM_SHIFT)
                   - scaled_product(scale, g, FRAC_BITS));
        v = longint'($signed(c[31:0]));
        clipped = c[32];
        c = clip32(w + v);
        w = longint'($signed(c[31:0]));
        clipped = clipped | c[32];
      end
      RULE_ADAPT: begin
        if ((g > 0 && pg > 0) || (g < 0 && pg < 0)) begin
          gain = gain + 64'(GAIN_STEP);
        end else begin
          gain = (gain * 64'(GAIN_DECAY)) >> FRAC_BITS;
        end
        if (gain > 64'(GAIN_MAX)) gain = 64'(GAIN_MAX);
        if (gain < 64'(GAIN_MIN)) gain = 64'(GAIN_MIN);
        sg = (scale * gain) >> FRAC_BITS;
        c = clip32(w - scaled_product(sg, g, FRAC_BITS));
        w = longint'($signed(c[31:0]));
        clipped = c[32];
        pg = g;
      end
      default: ;
    endcase
    r.weight_out    = w[31:0];
    r.velocity_out  = v[31:0];
    r.gain_out      = gain[22:0];
    r.prev_grad_out = pg[31:0];
    r.saturated     = clipped;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    nwu_out_t want;
    if (rst_n && out_valid) begin
      if (pending_updates.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %h", $time, out_data);
        fail_count++;
      end else begin
        want = pending_updates.pop_front();
        n_checked++;
        compare_field("weight_out", want.weight_out, out_data.weight_out);
        compare_field("velocity_out", want.velocity_out, out_data.velocity_out);
        compare_field("gain_out", 32'(want.gain_out), 32'(out_data.gain_out));
        compare_field("prev_grad_out", want.prev_grad_out, out_data.prev_grad_out);
        compare_field("saturated", 32'(want.saturated), 32'(out_data.saturated));
      end
    end
  end

  task automatic send_record(input nwu_in_t rec);
    if (!steady_flow && $urandom_range(99) < 28) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= rec;
    do @(posedge clk); while (busy);
    pending_updates.push_back(predict_update(rec));
  endtask

  task automatic wait_pipe_empty();
    start <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
  endtask

  // drain, then write all four registers in turn, waiting for cfg_ready on each
  task automatic program_regs(input rule_t rule, input logic [30:0] lr,
                              input logic [15:0] mom, input logic [15:0] batch);
    logic [CFG_IDX_W-1:0] idx[4];
    logic [31:0]          vals[4];
    idx  = '{REG_RULE, REG_LEARN, REG_MOM, REG_BATCH};
    vals = '{32'(rule), 32'(lr), 32'(mom), 32'(batch)};
    wait_pipe_empty();
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= vals[k];
      do @(posedge clk); while (!cfg_ready);
      case (idx[k])
        REG_RULE:  cur_rule  = rule_t'(vals[k][1:0]);
        REG_LEARN: cur_learn = vals[k][30:0];
        REG_MOM:   cur_mom   = vals[k][15:0];
        REG_BATCH: cur_batch = vals[k][15:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  function automatic nwu_in_t directed_record(input int k);
    nwu_in_t r;
    case (k)
      0: r = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, GAIN_MAX, 32'h8000_0000};
      1: r = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, GAIN_MIN, 32'h8000_0000};
      2: r = '{32'h0, 32'h0, 32'h0, 23'h0, 32'h0};
      3: r = '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 23'h7F_FFFF, 32'h0};
      default: r = '{32'hFFFF_FFFF, 32'h1, 32'h1, 23'h01_0000, 32'h7FFF_FFFF};
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_q16();
    int unsigned sel;
    logic [31:0] v;
    sel = $urandom_range(99);
    if (sel < 50) begin
      v = $urandom;
    end else if (sel < 85) begin
      v = $urandom_range(262143);
      if ($urandom_range(1) == 1) v = -v;
    end else begin
      case ($urandom_range(4))
        0: v = 32'h7FFF_FFFF;
        1: v = 32'h8000_0000;
        2: v = 32'h0;
        3: v = 32'h1;
        default: v = 32'hFFFF_FFFF;
      endcase
    end
    return v;
  endfunction

  function automatic nwu_in_t rand_record();
    nwu_in_t r;
    int unsigned sel;
    r.weight_in   = rand_q16();
    r.grad_sum    = rand_q16();
    r.velocity_in = rand_q16();
    sel = $urandom_range(9);
    if (sel < 8) r.gain_in = 23'($urandom_range(GAIN_MAX, GAIN_MIN));
    else if (sel == 8) r.gain_in = 23'($urandom);
    else r.gain_in = $urandom_range(1) ? GAIN_MIN : GAIN_MAX;
    // bias the previous gradient towards same and opposite sign
    case ($urandom_range(3))
      2: r.prev_grad = r.grad_sum;
      3: r.prev_grad = -r.grad_sum;
      default: r.prev_grad = rand_q16();
    endcase
    return r;
  endfunction

  task automatic test_reset_passthrough();
    for (int k = 0; k < 2; k++) send_record(directed_record(k));
  endtask

  task automatic test_rule_extremes();
    for (int r = 1; r < 4; r++) begin
      program_regs(rule_t'(r), 31'h7FFF_FFFF, 16'hFFFF, 16'd1);
      for (int k = 0; k < 5; k++) send_record(directed_record(k));
    end
  endtask

  task automatic test_special_configs();
    // zero learning rate leaves the weight alone
    program_regs(RULE_FIXED, 31'd0, MOM_RESET, BATCH_RESET);
    send_record(directed_record(3));
    send_record(directed_record(4));
    // zero batch count counts as one
    program_regs(RULE_ADAPT, LEARN_RESET, MOM_RESET, 16'd0);
    send_record(directed_record(3));
    send_record(directed_record(4));
    // zero momentum drops the old velocity
    program_regs(RULE_MOM, LEARN_RESET, 16'd0, 16'hFFFF);
    send_record(directed_record(3));
    send_record(directed_record(4));
    program_regs(RULE_ADAPT, 31'd1, 16'd1, 16'hFFFF);
    send_record(directed_record(1));
    send_record(directed_record(2));
  endtask

  task automatic test_random();
    logic [30:0] lr;
    logic [15:0] mom;
    logic [15:0] batch;
    for (int p = 0; p < 13; p++) begin
      case ($urandom_range(9))
        0: lr = 31'd1;
        1: lr = 31'h7FFF_FFFF;
        2, 3: lr = 31'($urandom);
        default: lr = 31'($urandom_range(1 << 20, 1));
      endcase
      case ($urandom_range(9))
        0: mom = 16'd0;
        1: mom = 16'hFFFF;
        default: mom = 16'($urandom);
      endcase
      case ($urandom_range(9))
        0: batch = 16'd0;
        1: batch = 16'hFFFF;
        2: batch = 16'd1;
        3: batch = 16'($urandom);
        default: batch = 16'($urandom_range(64, 1));
      endcase
      program_regs(rule_t'(p % 4), lr, mom, batch);
      // first phase runs back to back
      steady_flow = (p == 0);
      repeat (150) send_record(rand_record());
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_passthrough();
    test_rule_extremes();
    test_special_configs();
    test_random();
    wait_pipe_empty();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (pending_updates.size() != 0) begin
      $display("%0t: %0d updates never came out", $time, pending_updates.size());
      fail_count++;
    end
    $display("Checked %0d weight updates over %0d register settings,", n_checked, n_settings);
    $display("covering all four rules, clipping, gain clamps and zero-valued registers.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: run timed out", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/nwu_pkg.sv
rtl/core/nwu_cfg.sv
rtl/core/nwu_pipe.sv
rtl/core/nn_weight_update_engine.sv
sim/testbench.sv
